[src/lzwe_pkg.sv]
// lzwe_pkg: types, constants and helper functions of the variable-width lzw encoder
// no dependencies; imported by every module of the block
`default_nettype none
package lzwe_pkg;

    localparam int DICT_ENTRIES = 4096;
    localparam int CODE_W       = 12;
    localparam int ADDR_W       = $clog2(DICT_ENTRIES);
    localparam int BITS_W       = 4;
    localparam int FREE_W       = CODE_W + 1;
    localparam int CLR_W        = 9;
    // byte codes sit at 0..256 depending on first_code, their child heads are cleared
    localparam logic [CLR_W-1:0] CLR_LAST = 9'd256;
    localparam logic [CODE_W-1:0] NULL_CODE = '0;

    localparam logic [1:0] REG_FIRST_CODE = 2'd0;
    localparam logic [1:0] REG_MAX_CODE   = 2'd1;
    localparam logic [1:0] REG_START_BITS = 2'd2;

    localparam logic OP_DATA = 1'b0;
    localparam logic OP_END  = 1'b1;

    typedef struct packed {
        logic       operation;
        logic [7:0] data_byte;
    } in_t;

    typedef struct packed {
        logic [CODE_W-1:0] code_value;
        logic [BITS_W-1:0] code_bits;
        logic              is_mark;
        logic              error;
        logic              last;
    } result_t;

    // trie node: first child, next sibling, byte of the edge into this node
    typedef struct packed {
        logic [CODE_W-1:0] head;
        logic [CODE_W-1:0] sib;
        logic [7:0]        chr;
    } node_t;

    typedef struct packed {
        logic              two;
        result_t           r0;
        result_t           r1;
        logic [BITS_W-1:0] width;
    } emit_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK,
        ST_WALK,
        ST_INS
    } state_t;

    // number of bits a code needs, at least one
    function automatic logic [BITS_W:0] bit_len(input logic [CODE_W-1:0] code);
        logic [BITS_W:0] n;
        n = (BITS_W+1)'(1);
        for (int i = 0; i < CODE_W; i++) begin
            if (code[i]) n = (BITS_W+1)'(i + 1);
        end
        return n;
    endfunction

    // code word, preceded by a zero mark when the width grows by one; error flag if it grows by more
    function automatic emit_t emit_code(input logic [CODE_W-1:0] code,
                                        input logic [BITS_W-1:0] width,
                                        input logic              last);
        emit_t           e;
        logic [BITS_W:0] need;
        logic [BITS_W:0] wide;
        need = bit_len(code);
        wide = {1'b0, width};
        e.two   = 1'b0;
        e.width = width;
        e.r0    = '{code_value: code, code_bits: width, is_mark: 1'b0,
                    error: 1'b0, last: last};
        e.r1    = e.r0;
        if (need > wide) begin
            if (need == wide + (BITS_W+1)'(1)) begin
                e.two   = 1'b1;
                e.width = need[BITS_W-1:0];
                e.r0    = '{code_value: '0, code_bits: width, is_mark: 1'b1,
                            error: 1'b0, last: 1'b0};
                e.r1    = '{code_value: code, code_bits: need[BITS_W-1:0], is_mark: 1'b0,
                            error: 1'b0, last: last};
            end else begin
                e.r0.error = 1'b1;
            end
        end
        return e;
    endfunction

endpackage
`default_nettype wire

[src/lzwe_dict.sv]
// lzwe_dict: trie node memory, one write port and one registered read port
// depends on lzwe_pkg
`default_nettype none
module lzwe_dict (
    input  wire                          aclk,
    input  wire                          wr_en,
    input  wire  [lzwe_pkg::ADDR_W-1:0]  wr_addr,
    input  lzwe_pkg::node_t              wr_data,
    input  wire                          rd_en,
    input  wire  [lzwe_pkg::ADDR_W-1:0]  rd_addr,
    output lzwe_pkg::node_t              rd_data
);
    import lzwe_pkg::*;

    node_t mem [DICT_ENTRIES];
    node_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

[src/lzwe_outq.sv]
// lzwe_outq: four-entry output queue taking up to two words per cycle
// depends on lzwe_pkg
`default_nettype none
module lzwe_outq (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 push0,
    input  lzwe_pkg::result_t   push0_data,
    input  wire                 push1,
    input  lzwe_pkg::result_t   push1_data,
    output logic                room,
    output logic                m_valid,
    input  wire                 m_ready,
    output lzwe_pkg::result_t   m_data
);
    import lzwe_pkg::*;

    result_t    q_reg [4];
    logic [1:0] wr_reg, wr_next;
    logic [1:0] rd_reg, rd_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       pop;
    logic [2:0] n_push;

    assign m_valid = (cnt_reg != 3'd0);
    assign m_data  = q_reg[rd_reg];
    assign room    = (cnt_reg <= 3'd2);
    assign pop     = m_valid && m_ready;

    always_comb begin
        n_push   = {2'b00, push0} + {2'b00, push0 && push1};
        wr_next  = wr_reg + n_push[1:0];
        rd_next  = rd_reg + {1'b0, pop};
        cnt_next = cnt_reg + n_push - {2'b00, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push0) begin
            q_reg[wr_reg] <= push0_data;
        end
        if (push0 && push1) begin
            q_reg[wr_reg + 2'd1] <= push1_data;
        end
    end

endmodule
`default_nettype wire

[src/lzw_encoder_variable_width.sv]
// lzw_encoder_variable_width: top level, control sequencer of the lzw encoder
// depends on lzwe_pkg, lzwe_dict and lzwe_outq
//
// Usage: bytes and end-of-stream commands enter on s_valid/s_ready/s_data; code
// words leave on m_valid/m_ready/m_data, up to two per input (a zero width mark,
// then the code). The dictionary is a trie in one memory: every code keeps its
// first child, its next sibling and its byte, and a byte is looked up by walking
// the sibling list of the current prefix one memory read per cycle.
// An end command or the first byte of a stream is handled in ST_IDLE alone; any
// other byte reads its prefix's node (ST_LOOK), then the child nodes one by one
// up to a hit or the end of the list (ST_WALK), and goes through ST_INS when a
// new code is inserted.
// Reset and any write to a known register restart the stream and run a clearing
// pass over the child lists of byte codes 0..256; no byte is taken meanwhile.
// Results wait in a four-entry queue, so a stalled receiver holds them there;
// the next item is taken while at most two words are still queued.
`default_nettype none
module lzw_encoder_variable_width (
    input  wire                                    aclk,
    input  wire                                    aresetn,
    input  wire                                    s_valid,
    output logic                                   s_ready,
    input  lzwe_pkg::in_t                          s_data,
    output logic                                   m_valid,
    input  wire                                    m_ready,
    output lzwe_pkg::result_t                      m_data,
    input  wire                                    cfg_wr_en,
    input  wire  [1:0]                             cfg_index,
    input  wire  [lzwe_pkg::CODE_W-1:0]            cfg_wdata
);
    import lzwe_pkg::*;

    state_t              state_reg, state_next;
    logic [CLR_W-1:0]    clr_reg, clr_next;
    logic                first_reg;
    logic [CODE_W-1:0]   max_reg;
    logic [BITS_W-1:0]   start_reg;
    logic [CODE_W-1:0]   prefix_reg, prefix_next;
    logic                have_reg, have_next;
    logic [FREE_W-1:0]   free_reg, free_next;
    logic [BITS_W-1:0]   width_reg, width_next;
    logic [7:0]          chr_reg, chr_next;
    logic [CODE_W-1:0]   cur_reg, cur_next;
    node_t               pnode_reg, pnode_next;
    logic [CODE_W-1:0]   ins_reg, ins_next;

    logic                wr_en, rd_en;
    logic [ADDR_W-1:0]   wr_addr, rd_addr;
    node_t               wr_data, rd_data;
    logic                push0, push1, room;
    result_t             push0_data, push1_data;
    logic                accept, miss;
    emit_t               em;
    logic [CODE_W-1:0]   chr_code;
    logic [CODE_W-1:0]   in_code;
    logic                restart;

    lzwe_dict u_dict (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    lzwe_outq u_outq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push0      (push0),
        .push0_data (push0_data),
        .push1      (push1),
        .push1_data (push1_data),
        .room       (room),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

    assign restart = cfg_wr_en && (cfg_index == REG_FIRST_CODE ||
                     cfg_index == REG_MAX_CODE || cfg_index == REG_START_BITS);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_reg <= 1'b1;
            max_reg   <= CODE_W'(4095);
            start_reg <= BITS_W'(9);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_FIRST_CODE: first_reg <= cfg_wdata[0];
                REG_MAX_CODE:   max_reg   <= cfg_wdata;
                REG_START_BITS: start_reg <= cfg_wdata[BITS_W-1:0];
                default: ;
            endcase
        end
    end

    assign s_ready  = (state_reg == ST_IDLE) && room;
    assign accept   = s_valid && s_ready;
    assign chr_code = CODE_W'(chr_reg) + CODE_W'(first_reg);
    assign in_code  = CODE_W'(s_data.data_byte) + CODE_W'(first_reg);

    always_comb begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        prefix_next = prefix_reg;
        have_next   = have_reg;
        free_next   = free_reg;
        width_next  = width_reg;
        chr_next    = chr_reg;
        cur_next    = cur_reg;
        pnode_next  = pnode_reg;
        ins_next    = ins_reg;
        wr_en       = 1'b0;
        wr_addr     = '0;
        wr_data     = '0;
        rd_en       = 1'b0;
        rd_addr     = prefix_reg[ADDR_W-1:0];
        push0       = 1'b0;
        push1       = 1'b0;
        miss        = 1'b0;
        em          = emit_code(prefix_reg, width_reg, 1'b1);
        push0_data  = em.r0;
        push1_data  = em.r1;

        unique case (state_reg)
            ST_CLEAR: begin
                prefix_next = '0;
                have_next   = 1'b0;
                free_next   = FREE_W'(256) + FREE_W'(first_reg);
                width_next  = start_reg;
                wr_en       = 1'b1;
                wr_addr     = ADDR_W'(clr_reg);
                clr_next    = clr_reg + CLR_W'(1);
                if (clr_reg == CLR_LAST) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    if (s_data.operation == OP_END) begin
                        push0 = 1'b1;
                        if (have_reg) begin
                            push1      = em.two;
                            width_next = em.width;
                        end else begin
                            push0_data = '{code_value: '0, code_bits: '0, is_mark: 1'b0,
                                           error: 1'b0, last: 1'b1};
                        end
                        have_next   = 1'b0;
                        prefix_next = '0;
                    end else if (!have_reg) begin
                        prefix_next = in_code;
                        have_next   = 1'b1;
                    end else begin
                        chr_next   = s_data.data_byte;
                        rd_en      = 1'b1;
                        state_next = ST_LOOK;
                    end
                end
            end
            ST_LOOK: begin
                pnode_next = rd_data;
                if (rd_data.head == NULL_CODE) begin
                    miss = 1'b1;
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = rd_data.head[ADDR_W-1:0];
                    cur_next   = rd_data.head;
                    state_next = ST_WALK;
                end
            end
            ST_WALK: begin
                if (rd_data.chr == chr_reg) begin
                    prefix_next = cur_reg;
                    state_next  = ST_IDLE;
                end else if (rd_data.sib == NULL_CODE) begin
                    miss = 1'b1;
                end else begin
                    rd_en    = 1'b1;
                    rd_addr  = rd_data.sib[ADDR_W-1:0];
                    cur_next = rd_data.sib;
                end
            end
            ST_INS: begin
                // link the new code at the head of the old prefix's child list
                wr_en      = 1'b1;
                wr_addr    = prefix_reg[ADDR_W-1:0];
                wr_data    = '{head: ins_reg, sib: pnode_reg.sib, chr: pnode_reg.chr};
                prefix_next = chr_code;
                state_next = ST_IDLE;
            end
            default: state_next = ST_CLEAR;
        endcase

        if (miss) begin
            em         = emit_code(prefix_reg, width_reg, 1'b0);
            push0      = 1'b1;
            push1      = em.two;
            push0_data = em.r0;
            push1_data = em.r1;
            width_next = em.width;
            state_next = ST_IDLE;
            prefix_next = chr_code;
            if (free_reg <= {1'b0, max_reg}) begin
                wr_en      = 1'b1;
                wr_addr    = free_reg[ADDR_W-1:0];
                wr_data    = '{head: NULL_CODE,
                               sib: (state_reg == ST_LOOK) ? rd_data.head : pnode_reg.head,
                               chr: chr_reg};
                ins_next   = free_reg[CODE_W-1:0];
                free_next  = free_reg + FREE_W'(1);
                prefix_next = prefix_reg;
                state_next = ST_INS;
            end
        end

        if (restart) begin
            state_next = ST_CLEAR;
            clr_next   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_CLEAR;
            clr_reg    <= '0;
            prefix_reg <= '0;
            have_reg   <= 1'b0;
            free_reg   <= '0;
            width_reg  <= '0;
        end else begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            prefix_reg <= prefix_next;
            have_reg   <= have_next;
            free_reg   <= free_next;
            width_reg  <= width_next;
        end
    end

    always_ff @(posedge aclk) begin
        chr_reg   <= chr_next;
        cur_reg   <= cur_next;
        pnode_reg <= pnode_next;
        ins_reg   <= ins_next;
    end

endmodule
`default_nettype wire
